// File: rtl/sth_pkg.sv
// shared constants, types and table build functions for the sine/cosine table evaluator
package sth_pkg;

  localparam int TABLE_POINTS = 512;
  localparam int QUARTER      = TABLE_POINTS / 4;
  localparam int DEPTH        = TABLE_POINTS + 1;
  localparam int ADDR_W       = $clog2(DEPTH);
  localparam int IDX_W        = $clog2(TABLE_POINTS);
  localparam int QIDX_W       = $clog2(QUARTER + 1);
  localparam int MQ_W         = $clog2(QUARTER);
  localparam int ROM_W        = 32;
  localparam int QTAB_W       = 31;
  localparam int T_W          = 30;
  localparam int CW           = 34;
  localparam int XW           = 32 + IDX_W;

  localparam logic [63:0] PI_Q49         = 64'h0006_487E_D511_0B46;
  localparam logic [63:0] ONE_Q60        = 64'h1000_0000_0000_0000;
  localparam logic [29:0] INV_TWO_PI_Q32 = 30'h28BE_60DC;
  localparam logic signed [31:0] Q30_ONE = 32'sh4000_0000;

  localparam logic [63:0] DELTA_FULL =
    (PI_Q49 + (64'(TABLE_POINTS) << 15)) / (64'(TABLE_POINTS) << 16);
  localparam int DELTA_W = $clog2(DELTA_FULL + 64'd1);
  localparam logic [DELTA_W-1:0] DELTA = DELTA_FULL[DELTA_W-1:0];

  typedef logic [QTAB_W-1:0] qtab_t [QUARTER+1];

  typedef struct packed {
    logic ld3;
    logic ld4;
    logic ld5;
    logic ld6;
  } stage_ld_t;

  function automatic logic [63:0] mul_q60(input logic [63:0] x, input logic [63:0] y);
    logic [127:0] p;
    p = {64'd0, x} * {64'd0, y};
    return p[123:60];
  endfunction

  // sin((pi/2) * r / TABLE_POINTS) in q30, taylor series in q60
  function automatic logic [QTAB_W-1:0] quarter_sine(input logic [63:0] r);
    logic [63:0] a;
    logic [63:0] a2;
    logic [63:0] p;
    logic [63:0] s;
    a  = ((PI_Q49 * r) / 64'(TABLE_POINTS)) << 10;
    a2 = mul_q60(a, a);
    p  = ONE_Q60;
    p  = ONE_Q60 - mul_q60(a2, p) / 64'd600;
    p  = ONE_Q60 - mul_q60(a2, p) / 64'd506;
    p  = ONE_Q60 - mul_q60(a2, p) / 64'd420;
    p  = ONE_Q60 - mul_q60(a2, p) / 64'd342;
    p  = ONE_Q60 - mul_q60(a2, p) / 64'd272;
    p  = ONE_Q60 - mul_q60(a2, p) / 64'd210;
    p  = ONE_Q60 - mul_q60(a2, p) / 64'd156;
    p  = ONE_Q60 - mul_q60(a2, p) / 64'd110;
    p  = ONE_Q60 - mul_q60(a2, p) / 64'd72;
    p  = ONE_Q60 - mul_q60(a2, p) / 64'd42;
    p  = ONE_Q60 - mul_q60(a2, p) / 64'd20;
    p  = ONE_Q60 - mul_q60(a2, p) / 64'd6;
    s  = (mul_q60(a, p) + 64'd536870912) >> 30;
    if (s > 64'd1073741824) begin
      s = 64'd1073741824;
    end
    return s[QTAB_W-1:0];
  endfunction

  function automatic qtab_t build_qtab();
    qtab_t q;
    for (int m = 0; m <= QUARTER; m++) begin
      q[m] = quarter_sine(64'(4 * m));
    end
    return q;
  endfunction

  localparam qtab_t QTAB = build_qtab();

endpackage

// File: rtl/sth_ram.sv
// generic ram, one write port and two registered read ports
module sth_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 513,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr_a,
  input  logic [AW-1:0]    rd_addr_b,
  output logic [WIDTH-1:0] rd_data_a,
  output logic [WIDTH-1:0] rd_data_b
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_a_r;
  logic [WIDTH-1:0] rd_data_b_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_a_r <= mem_r[rd_addr_a];
      rd_data_b_r <= mem_r[rd_addr_b];
    end
  end

  assign rd_data_a = rd_data_a_r;
  assign rd_data_b = rd_data_b_r;

endmodule

// File: rtl/sth_hermite.sv
// four-stage cubic hermite interpolation pipeline for one output channel
module sth_hermite (
  input  logic                            clk,
  input  sth_pkg::stage_ld_t              ld,
  input  logic [sth_pkg::T_W-1:0]         t_in,
  input  logic                            neg_in,
  input  logic signed [sth_pkg::ROM_W:0]  f1_in,
  input  logic signed [sth_pkg::ROM_W:0]  f2_in,
  input  logic signed [sth_pkg::ROM_W:0]  d1_in,
  input  logic signed [sth_pkg::ROM_W:0]  d2_in,
  output logic signed [31:0]              h_out
);

  localparam int CW   = sth_pkg::CW;
  localparam int TW   = sth_pkg::T_W;
  localparam int PW   = CW + TW + 1;
  localparam int GPW  = sth_pkg::DELTA_W + sth_pkg::ROM_W + 2;
  localparam logic signed [PW-1:0]  HALF30 = {{(PW-30){1'b0}}, 1'b1, 29'd0};
  localparam logic signed [GPW-1:0] HALF32 = {{(GPW-32){1'b0}}, 1'b1, 31'd0};
  localparam logic signed [CW-1:0]  ONE_CW = CW'(sth_pkg::Q30_ONE);

  function automatic logic signed [CW-1:0] rnd30(input logic signed [PW-1:0] v);
    logic signed [PW-1:0] b;
    b = v + HALF30;
    return CW'(b >>> 30);
  endfunction

  function automatic logic signed [CW-1:0] rnd32(input logic signed [GPW-1:0] v);
    logic signed [GPW-1:0] b;
    b = v + HALF32;
    return CW'(b >>> 32);
  endfunction

  logic signed [sth_pkg::DELTA_W:0] delta_s;
  logic signed [GPW-1:0] gp1, gp2;
  logic signed [CW-1:0]  df, g1, g2, c3, c2;
  logic signed [PW-1:0]  m4, m5, m6;
  logic signed [CW-1:0]  acc2, acc1, h, hc;

  logic signed [sth_pkg::ROM_W:0] f1_3_r, f1_4_r, f1_5_r;
  logic signed [CW-1:0]  g1_3_r, c2_3_r, c3_3_r, g1_4_r, acc2_4_r, acc1_5_r;
  logic [TW-1:0]         t_3_r, t_4_r, t_5_r;
  logic                  neg_3_r, neg_4_r, neg_5_r;
  logic signed [31:0]    h_6_r;
  logic signed [31:0]    h_nxt;

  // slope terms and polynomial coefficients
  always_comb begin
    delta_s = $signed({1'b0, sth_pkg::DELTA});
    gp1     = delta_s * d1_in;
    gp2     = delta_s * d2_in;
    g1      = rnd32(gp1);
    g2      = rnd32(gp2);
    df      = CW'(f2_in) - CW'(f1_in);
    c3      = g1 + g2 - (df <<< 1);
    c2      = df + (df <<< 1) - g2 - (g1 <<< 1);
  end

  always_comb begin
    m4   = $signed({1'b0, t_3_r}) * c3_3_r;
    acc2 = c2_3_r + rnd30(m4);
    m5   = $signed({1'b0, t_4_r}) * acc2_4_r;
    acc1 = g1_4_r + rnd30(m5);
    m6   = $signed({1'b0, t_5_r}) * acc1_5_r;
    h    = CW'(f1_5_r) + rnd30(m6);
    if (h > ONE_CW) begin
      hc = ONE_CW;
    end else if (h < -ONE_CW) begin
      hc = -ONE_CW;
    end else begin
      hc = h;
    end
    h_nxt = neg_5_r ? 32'(-hc) : 32'(hc);
  end

  always_ff @(posedge clk) begin
    if (ld.ld3) begin
      f1_3_r  <= f1_in;
      g1_3_r  <= g1;
      c2_3_r  <= c2;
      c3_3_r  <= c3;
      t_3_r   <= t_in;
      neg_3_r <= neg_in;
    end
    if (ld.ld4) begin
      f1_4_r   <= f1_3_r;
      g1_4_r   <= g1_3_r;
      acc2_4_r <= acc2;
      t_4_r    <= t_3_r;
      neg_4_r  <= neg_3_r;
    end
    if (ld.ld5) begin
      f1_5_r   <= f1_4_r;
      acc1_5_r <= acc1;
      t_5_r    <= t_4_r;
      neg_5_r  <= neg_4_r;
    end
    if (ld.ld6) begin
      h_6_r <= h_nxt;
    end
  end

  assign h_out = h_6_r;

endmodule

// File: rtl/sincos_table_hermite.sv
// sine and cosine of a q8.24 radian angle from a sine table with cubic hermite interpolation
//
// One angle per clock is taken while the output is not stalled, and each result passes through
// registered stages for turn scaling, table address and read, slope terms, then three steps
// of the hermite polynomial, each step one multiplier and one register. The sine table of
// TABLE_POINTS+1 entries sits in two copies of a ram with two read ports each, so the
// four table points an angle needs are read in the same cycle. After reset the rams are loaded
// from a quarter-wave table, one entry a cycle, all TABLE_POINTS+1 entries (513 at the default
// size), and in_tready stays low until that load is done. Stages hold their data under
// backpressure and empty stages fill up, so input transfers go on while a result waits.
// Outputs are q1.30 and saturated to plus or minus one; only the sine follows the sign.
module sincos_table_hermite (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] angle_rad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata   // [31:0] sine_out, [63:32] cosine_out
);

  localparam int AW = sth_pkg::ADDR_W;
  localparam int IW = sth_pkg::IDX_W;
  localparam int XW = sth_pkg::XW;

  // table load sequencer
  logic [AW-1:0]             fill_cnt_r;
  logic [1:0]                fill_q_r;
  logic [sth_pkg::MQ_W-1:0]  fill_m_r;
  logic                      fill_done_r;
  logic [sth_pkg::QIDX_W-1:0] fill_qidx;
  logic [31:0]               fill_mag;
  logic [31:0]               fill_data;

  always_comb begin
    fill_qidx = fill_q_r[0] ?
      (sth_pkg::QIDX_W'(sth_pkg::QUARTER) - sth_pkg::QIDX_W'(fill_m_r)) :
      sth_pkg::QIDX_W'(fill_m_r);
    fill_mag  = {1'b0, sth_pkg::QTAB[fill_qidx]};
    fill_data = fill_q_r[1] ? (32'd0 - fill_mag) : fill_mag;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_cnt_r  <= '0;
      fill_q_r    <= '0;
      fill_m_r    <= '0;
      fill_done_r <= 1'b0;
    end else if (!fill_done_r) begin
      if (fill_cnt_r == AW'(sth_pkg::TABLE_POINTS)) begin
        fill_done_r <= 1'b1;
      end else begin
        fill_cnt_r <= fill_cnt_r + AW'(1);
      end
      if (fill_m_r == sth_pkg::MQ_W'(sth_pkg::QUARTER - 1)) begin
        fill_m_r <= '0;
        fill_q_r <= fill_q_r + 2'd1;
      end else begin
        fill_m_r <= fill_m_r + sth_pkg::MQ_W'(1);
      end
    end
  end

  // stage valids and per-stage ready
  logic [6:1] vld_r;
  logic [6:1] vld_nxt;
  logic [7:1] rdy;
  logic [6:1] vin;
  logic       in_xfer;

  always_comb begin
    rdy[7] = out_tready;
    for (int k = 6; k >= 1; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
  end

  assign in_tready = rdy[1] && fill_done_r;
  assign in_xfer   = in_tvalid && in_tready;
  assign vin       = {vld_r[5:1], in_xfer};

  always_comb begin
    for (int k = 1; k <= 6; k++) begin
      vld_nxt[k] = rdy[k] ? vin[k] : vld_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // stage 1: magnitude times 1/(2*pi), keep the fractional turn
  logic [31:0] mag;
  logic [61:0] turn;
  logic [31:0] f32_r;
  logic        neg1_r;

  always_comb begin
    mag  = in_tdata[31] ? (~in_tdata + 32'd1) : in_tdata;
    turn = 62'(mag) * 62'(sth_pkg::INV_TWO_PI_Q32);
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      f32_r  <= turn[55:24];
      neg1_r <= in_tdata[31];
    end
  end

  // stage 2: table index, quarter offset and fraction, ram read
  logic [XW-1:0] x;
  logic [IW-1:0] idx;
  logic [IW:0]   jsum;
  logic [IW-1:0] jdx;
  logic [AW-1:0] addr_i, addr_i1, addr_j, addr_j1;
  logic [sth_pkg::T_W-1:0] t2_r;
  logic          neg2_r;

  always_comb begin
    x    = XW'(f32_r) * XW'(sth_pkg::TABLE_POINTS);
    idx  = x[XW-1:32];
    jsum = (IW+1)'(idx) + (IW+1)'(sth_pkg::QUARTER);
    if (jsum >= (IW+1)'(sth_pkg::TABLE_POINTS)) begin
      jdx = IW'(jsum - (IW+1)'(sth_pkg::TABLE_POINTS));
    end else begin
      jdx = IW'(jsum);
    end
    addr_i  = AW'(idx);
    addr_i1 = AW'(idx) + AW'(1);
    addr_j  = AW'(jdx);
    addr_j1 = AW'(jdx) + AW'(1);
  end

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      t2_r   <= x[31:2];
      neg2_r <= neg1_r;
    end
  end

  logic [31:0] s_i, s_i1, c_j, c_j1;

  sth_ram #(
    .WIDTH (sth_pkg::ROM_W),
    .DEPTH (sth_pkg::DEPTH)
  ) u_ram_sin (
    .clk       (clk),
    .wr_en     (!fill_done_r),
    .wr_addr   (fill_cnt_r),
    .wr_data   (fill_data),
    .rd_en     (rdy[2]),
    .rd_addr_a (addr_i),
    .rd_addr_b (addr_i1),
    .rd_data_a (s_i),
    .rd_data_b (s_i1)
  );

  sth_ram #(
    .WIDTH (sth_pkg::ROM_W),
    .DEPTH (sth_pkg::DEPTH)
  ) u_ram_cos (
    .clk       (clk),
    .wr_en     (!fill_done_r),
    .wr_addr   (fill_cnt_r),
    .wr_data   (fill_data),
    .rd_en     (rdy[2]),
    .rd_addr_a (addr_j),
    .rd_addr_b (addr_j1),
    .rd_data_a (c_j),
    .rd_data_b (c_j1)
  );

  // stages 3 to 6
  sth_pkg::stage_ld_t ld;
  logic signed [32:0] s_i_x, s_i1_x, c_j_x, c_j1_x, ns_i_x, ns_i1_x;
  logic signed [31:0] sin_h, cos_h;

  always_comb begin
    ld.ld3  = rdy[3];
    ld.ld4  = rdy[4];
    ld.ld5  = rdy[5];
    ld.ld6  = rdy[6];
    s_i_x   = $signed({s_i[31], s_i});
    s_i1_x  = $signed({s_i1[31], s_i1});
    c_j_x   = $signed({c_j[31], c_j});
    c_j1_x  = $signed({c_j1[31], c_j1});
    ns_i_x  = 33'sd0 - s_i_x;
    ns_i1_x = 33'sd0 - s_i1_x;
  end

  sth_hermite u_herm_sin (
    .clk    (clk),
    .ld     (ld),
    .t_in   (t2_r),
    .neg_in (neg2_r),
    .f1_in  (s_i_x),
    .f2_in  (s_i1_x),
    .d1_in  (c_j_x),
    .d2_in  (c_j1_x),
    .h_out  (sin_h)
  );

  sth_hermite u_herm_cos (
    .clk    (clk),
    .ld     (ld),
    .t_in   (t2_r),
    .neg_in (1'b0),
    .f1_in  (c_j_x),
    .f2_in  (c_j1_x),
    .d1_in  (ns_i_x),
    .d2_in  (ns_i1_x),
    .h_out  (cos_h)
  );

  assign out_tvalid = vld_r[6];
  assign out_tdata  = {cos_h, sin_h};

`ifndef NO_ASSERTIONS
  a_fill_hold: assert property (@(posedge clk) disable iff (!rst_n)
    fill_done_r |=> fill_done_r)
    else $error("table load flag dropped after load");

  a_fill_end: assert property (@(posedge clk) disable iff (!rst_n)
    (!fill_done_r && fill_cnt_r == AW'(sth_pkg::TABLE_POINTS)) |=> fill_done_r)
    else $error("table load did not finish at last entry");

  a_fill_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !fill_done_r |-> (vld_r == '0))
    else $error("pipeline holds an item during table load");

  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !rdy[1] |-> (&vld_r))
    else $error("input stalled while pipeline has a bubble");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (($signed(out_tdata[31:0]) <= sth_pkg::Q30_ONE)
                 && ($signed(out_tdata[31:0]) >= -sth_pkg::Q30_ONE)
                 && ($signed(out_tdata[63:32]) <= sth_pkg::Q30_ONE)
                 && ($signed(out_tdata[63:32]) >= -sth_pkg::Q30_ONE)))
    else $error("result outside plus or minus one");
`endif

endmodule

// File: verif/sincos_table_hermite_tb.sv
// self-checking testbench for the sine/cosine table evaluator with hermite interpolation
module sincos_table_hermite_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int POINTS = sth_pkg::TABLE_POINTS;
  localparam logic [63:0] PI_Q49 = 64'h0006_487E_D511_0B46;
  localparam logic [63:0] ONE_Q60 = 64'h1000_0000_0000_0000;
  localparam logic [63:0] INV_TURN_Q32 = 64'h28BE_60DC;
  localparam longint Q30_UNITY = 64'sd1073741824;
  localparam logic [31:0] HALF_PI_Q24 = 32'd26353589;
  localparam logic [31:0] PI_Q24 = 32'd52707179;
  localparam logic [31:0] TWO_PI_Q24 = 32'd105414357;
  localparam logic [31:0] STEP_Q24 = 32'd205887;

  typedef struct {
    logic [31:0] sine;
    logic [31:0] cosine;
  } sincos_pair_t;

  class sincos_scoreboard;
    longint sine_rom [POINTS+1];
    longint slope_step;
    sincos_pair_t expected_pairs [$];
    int failures;

    function new();
      logic [63:0] quad;
      logic [63:0] rem;
      longint v;
      failures = 0;
      slope_step = longint'((PI_Q49 + (64'(POINTS) << 15)) / (64'(POINTS) << 16));
      for (int i = 0; i <= POINTS; i++) begin
        quad = 64'(4 * (i % POINTS)) / 64'(POINTS);
        rem = 64'(4 * (i % POINTS)) - quad * 64'(POINTS);
        v = quad[0] ? quarter_wave(64'(POINTS) - rem) : quarter_wave(rem);
        sine_rom[i] = quad[1] ? -v : v;
      end
    endfunction

    function logic [63:0] q60_product(logic [63:0] x, logic [63:0] y);
      logic [127:0] p;
      p = 128'(x) * 128'(y);
      return 64'(p >> 60);
    endfunction

    // sin(pi/2 * r / POINTS) in q30 from a taylor series in q60
    function longint quarter_wave(logic [63:0] r);
      logic [63:0] a;
      logic [63:0] a2;
      logic [63:0] p;
      logic [63:0] s;
      a = ((PI_Q49 * r) / 64'(POINTS)) << 10;
      a2 = q60_product(a, a);
      p = ONE_Q60;
      for (int k = 12; k >= 1; k--) begin
        p = ONE_Q60 - q60_product(a2, p) / 64'((2 * k) * (2 * k + 1));
      end
      s = (q60_product(a, p) + 64'd536870912) >> 30;
      if (s > 64'd1073741824) begin
        s = 64'd1073741824;
      end
      return longint'(s);
    endfunction

    function longint round_shift(longint v, int sh);
      return (v + (longint'(1) <<< (sh - 1))) >>> sh;
    endfunction

    function longint hermite_point(longint f1, longint f2, longint d1, longint d2, longint t);
      longint df;
      longint g1;
      longint g2;
      longint acc;
      df = f2 - f1;
      g1 = round_shift(slope_step * d1, 32);
      g2 = round_shift(slope_step * d2, 32);
      acc = g1 + g2 - 2 * df;
      acc = (3 * df - g2 - 2 * g1) + round_shift(t * acc, 30);
      acc = g1 + round_shift(t * acc, 30);
      acc = f1 + round_shift(t * acc, 30);
      if (acc > Q30_UNITY) begin
        acc = Q30_UNITY;
      end
      if (acc < -Q30_UNITY) begin
        acc = -Q30_UNITY;
      end
      return acc;
    endfunction

    function void note_angle(logic [31:0] angle);
      logic [63:0] mag;
      logic [63:0] turn;
      logic [63:0] x;
      int idx;
      int jdx;
      longint t;
      longint s;
      longint c;
      sincos_pair_t want;
      mag = angle[31] ? 64'(32'(~angle + 32'd1)) : 64'(angle);
      turn = mag * INV_TURN_Q32;
      x = 64'(POINTS) * 64'(turn[55:24]);
      idx = int'(x >> 32);
      jdx = (idx + POINTS / 4) % POINTS;
      t = longint'(x[31:2]);
      s = hermite_point(sine_rom[idx], sine_rom[idx+1], sine_rom[jdx], sine_rom[jdx+1], t);
      c = hermite_point(sine_rom[jdx], sine_rom[jdx+1], -sine_rom[idx], -sine_rom[idx+1], t);
      if (angle[31]) begin
        s = -s;
      end
      want.sine = 32'(s);
      want.cosine = 32'(c);
      expected_pairs.push_back(want);
    endfunction

    function void report(string what, logic [31:0] want, logic [31:0] got);
      failures++;
      if (failures <= 10) begin
        $display("%0t ns: %s mismatch, expected %h, got %h", $realtime, what, want, got);
      end
    endfunction

    function void check_result(logic [63:0] data);
      sincos_pair_t want;
      if (expected_pairs.size() == 0) begin
        failures++;
        if (failures <= 10) begin
          $display("%0t ns: result %h with nothing pending", $realtime, data);
        end
        return;
      end
      want = expected_pairs.pop_front();
      if (data[31:0] !== want.sine) begin
        report("sine", want.sine, data[31:0]);
      end
      if (data[63:32] !== want.cosine) begin
        report("cosine", want.cosine, data[63:32]);
      end
    endfunction

    function int pending();
      return expected_pairs.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [31:0] in_tdata;
  logic out_tvalid;
  logic out_tready;
  logic [63:0] out_tdata;

  int send_idle_odds;
  int stall_odds;
  sincos_scoreboard board;

  sincos_table_hermite dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    clk = 1'b0;
  end

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      board.check_result(out_tdata);
    end
  end

  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (rst_n && stall_odds != 0 && $urandom_range(1, 100) <= stall_odds) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(0, 15)) @(negedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic send_angle(input logic [31:0] angle);
    in_tvalid <= 1'b1;
    in_tdata <= angle;
    do begin
      @(posedge clk);
    end while (!in_tready);
    board.note_angle(angle);
    @(negedge clk);
    if (send_idle_odds != 0 && $urandom_range(1, 100) <= send_idle_odds) begin
      in_tvalid <= 1'b0;
      in_tdata <= $urandom;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
  endtask

  function automatic logic [31:0] random_angle();
    int kind;
    logic [31:0] a;
    kind = $urandom_range(0, 9);
    if (kind <= 3) begin
      a = $urandom;
    end else if (kind <= 6) begin
      a = 32'($urandom_range(0, 80)) * HALF_PI_Q24 + 32'($urandom_range(0, 512)) - 32'd256;
    end else begin
      a = 32'($urandom_range(0, 32'h07FF_FFFF));
    end
    if (kind > 3 && $urandom_range(0, 1) == 1) begin
      a = 32'(-a);
    end
    return a;
  endfunction

  initial begin
    logic [31:0] directed [$];
    int odds_menu [4];
    board = new();
    odds_menu = '{0, 10, 40, 70};
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = 32'd0;
    send_idle_odds = 30;
    stall_odds = 30;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    directed = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001,
                 HALF_PI_Q24, 32'(-HALF_PI_Q24), PI_Q24, 32'(-PI_Q24),
                 HALF_PI_Q24 + PI_Q24, TWO_PI_Q24, STEP_Q24, STEP_Q24 + 32'd1,
                 32'(-STEP_Q24), 32'h00FF_FFFF, 32'h0100_0000, 32'hFF00_0000,
                 32'h5555_5555, 32'hAAAA_AAAA, TWO_PI_Q24 * 32'd10, 32'h7FFF_FFFE,
                 HALF_PI_Q24 * 32'd81};
    foreach (directed[k]) begin
      send_angle(directed[k]);
    end

    // drain everything before the random part
    in_tvalid <= 1'b0;
    while (board.pending() != 0) begin
      @(negedge clk);
    end

    for (int n = 0; n < 1450; n++) begin
      if (n % 100 == 0) begin
        send_idle_odds = odds_menu[$urandom_range(0, 3)];
        stall_odds = odds_menu[$urandom_range(0, 3)];
      end
      if (n >= 1300) begin
        send_idle_odds = 0;
        stall_odds = 0;
      end
      send_angle(random_angle());
    end
    in_tvalid <= 1'b0;

    while (board.pending() != 0) begin
      @(posedge clk);
    end
    repeat (12) @(posedge clk);
    if (board.failures == 0 && board.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: sincos_table_hermite.f
rtl/sth_pkg.sv
rtl/sth_ram.sv
rtl/sth_hermite.sv
rtl/sincos_table_hermite.sv
verif/sincos_table_hermite_tb.sv
